>>> rtl/e2bmi_pkg.sv
`default_nettype none

package e2bmi_pkg;

  // field widths
  localparam int OFFSET_W = 48;
  localparam int LOG_W    = 2;
  localparam int LEVEL_W  = 2;
  localparam int SLOT_W   = 4;
  localparam int IDX_W    = 10;
  localparam int INBLK_W  = 12;

  // logical block number width at the smallest block size
  localparam int BLK_W = OFFSET_W - 10;
  // relative block number inside the triple-indirect tree, largest block size
  localparam int REL_W = 30;

  // inode layout
  localparam int DIRECT_SLOTS = 12;

  // block size settings
  localparam logic [LOG_W-1:0] LOG_MAX        = 2'd2;
  localparam logic [4:0]       PTR_SHIFT_BASE = 5'd8;
  localparam logic [4:0]       BYTE_SHIFT_ADD = 5'd2;

  // map level codes
  typedef enum logic [LEVEL_W-1:0] {
    LVL_DIRECT = 2'd0,
    LVL_SINGLE = 2'd1,
    LVL_DOUBLE = 2'd2,
    LVL_TRIPLE = 2'd3
  } map_level_t;

  // inode pointer slots of the indirect trees
  localparam logic [SLOT_W-1:0] SLOT_SINGLE = SLOT_W'(DIRECT_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_DOUBLE = SLOT_W'(DIRECT_SLOTS + 1);
  localparam logic [SLOT_W-1:0] SLOT_TRIPLE = SLOT_W'(DIRECT_SLOTS + 2);

  // one mapped result
  typedef struct packed {
    logic [LEVEL_W-1:0] map_level;
    logic [SLOT_W-1:0]  pointer_slot;
    logic [IDX_W-1:0]   first_index;
    logic [IDX_W-1:0]   second_index;
    logic [IDX_W-1:0]   third_index;
    logic [INBLK_W-1:0] offset_in_block;
    logic               beyond_range;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/e2bmi_off_if.sv
`default_nettype none

interface e2bmi_off_if;
  import e2bmi_pkg::*;

  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] byte_offset;

  modport source (output valid, output byte_offset, input ready);
  modport sink   (input valid, input byte_offset, output ready);
endinterface

`default_nettype wire

>>> rtl/e2bmi_res_if.sv
`default_nettype none

interface e2bmi_res_if;
  import e2bmi_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] map_level;
  logic [SLOT_W-1:0]  pointer_slot;
  logic [IDX_W-1:0]   first_index;
  logic [IDX_W-1:0]   second_index;
  logic [IDX_W-1:0]   third_index;
  logic [INBLK_W-1:0] offset_in_block;
  logic               beyond_range;

  modport source (
    output valid, output map_level, output pointer_slot, output first_index,
    output second_index, output third_index, output offset_in_block,
    output beyond_range, input ready
  );
  modport sink (
    input valid, input map_level, input pointer_slot, input first_index,
    input second_index, input third_index, input offset_in_block,
    input beyond_range, output ready
  );
endinterface

`default_nettype wire

>>> rtl/e2bmi_cfg_if.sv
`default_nettype none

interface e2bmi_cfg_if;
  import e2bmi_pkg::*;

  logic             valid;
  logic             ready;
  logic [LOG_W-1:0] log_block_size;

  modport source (output valid, output log_block_size, input ready);
  modport sink   (input valid, input log_block_size, output ready);
endinterface

`default_nettype wire

>>> rtl/e2bmi_map.sv
`default_nettype none

module e2bmi_map (
  input  logic [e2bmi_pkg::LOG_W-1:0]    log_block_size,
  input  logic [e2bmi_pkg::OFFSET_W-1:0] byte_offset,
  output e2bmi_pkg::res_t                res
);
  import e2bmi_pkg::*;

  logic [LOG_W-1:0]   lg;
  logic [4:0]         ps;
  logic [BLK_W-1:0]   blk;
  logic [INBLK_W-1:0] inblk;
  logic [BLK_W-1:0]   p1;
  logic [BLK_W-1:0]   p2;
  logic [BLK_W-1:0]   p3;
  logic [BLK_W-1:0]   base2;
  logic [BLK_W-1:0]   base3;
  logic [BLK_W-1:0]   lim;
  logic               in_direct;
  logic               in_single;
  logic               in_double;
  logic               in_triple;
  logic [REL_W-1:0]   base_sel;
  logic [REL_W-1:0]   rel;
  logic [IDX_W-1:0]   pmask;

  // block size, pointer count and logical block number
  always_comb begin
    lg    = (log_block_size > LOG_MAX) ? LOG_MAX : log_block_size;
    ps    = PTR_SHIFT_BASE + {3'b000, lg};
    blk   = BLK_W'(byte_offset >> (ps + BYTE_SHIFT_ADD));
    inblk = INBLK_W'(byte_offset)
            & INBLK_W'((13'd1 << (ps + BYTE_SHIFT_ADD)) - 13'd1);
    pmask = IDX_W'((11'd1 << ps) - 11'd1);
  end

  // start of each tree in logical blocks
  always_comb begin
    p1    = BLK_W'(1) << ps;
    p2    = BLK_W'(1) << {ps, 1'b0};
    p3    = p2 << ps;
    base2 = BLK_W'(DIRECT_SLOTS) + p1;
    base3 = base2 + p2;
    lim   = base3 + p3;
  end

  // level decision and block number relative to the chosen tree
  always_comb begin
    in_direct = blk < BLK_W'(DIRECT_SLOTS);
    in_single = blk < base2;
    in_double = blk < base3;
    in_triple = blk < lim;
    if (in_single) begin
      base_sel = REL_W'(DIRECT_SLOTS);
    end else if (in_double) begin
      base_sel = base2[REL_W-1:0];
    end else begin
      base_sel = base3[REL_W-1:0];
    end
    rel = blk[REL_W-1:0] - base_sel;
  end

  // split into per-level indexes
  always_comb begin
    res = '0;
    if (in_direct) begin
      res.map_level       = LVL_DIRECT;
      res.pointer_slot    = blk[SLOT_W-1:0];
      res.offset_in_block = inblk;
    end else if (in_single) begin
      res.map_level       = LVL_SINGLE;
      res.pointer_slot    = SLOT_SINGLE;
      res.first_index     = rel[IDX_W-1:0];
      res.offset_in_block = inblk;
    end else if (in_double) begin
      res.map_level       = LVL_DOUBLE;
      res.pointer_slot    = SLOT_DOUBLE;
      res.first_index     = IDX_W'(rel >> ps);
      res.second_index    = rel[IDX_W-1:0] & pmask;
      res.offset_in_block = inblk;
    end else if (in_triple) begin
      res.map_level       = LVL_TRIPLE;
      res.pointer_slot    = SLOT_TRIPLE;
      res.first_index     = IDX_W'(rel >> {ps, 1'b0});
      res.second_index    = IDX_W'(rel >> ps) & pmask;
      res.third_index     = rel[IDX_W-1:0] & pmask;
      res.offset_in_block = inblk;
    end else begin
      res.beyond_range    = 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ext2_block_map_indexer_top.sv
// Maps a file byte offset onto the ext2 block map (twelve direct pointers,
// then single, double and triple indirect trees) and returns the level, the
// inode pointer slot, the index in each indirect block on the path and the
// byte offset inside the data block; offsets past the triple-indirect reach
// come back flagged with all other fields zero. The block takes one offset
// per cycle unless rsp stalls it; between the req transfer and the result
// on rsp lie one input register, the mapping logic, one result register. The
// log block size (a setting of 3 acts as 2) is written over cfg, which is
// always ready, and should only change while no offset is in flight.
`default_nettype none

module ext2_block_map_indexer_top (
  input logic          clk,
  input logic          rst,
  e2bmi_off_if.sink    req,
  e2bmi_res_if.source  rsp,
  e2bmi_cfg_if.sink    cfg
);
  import e2bmi_pkg::*;

  logic [LOG_W-1:0]    log_block_size;
  logic                a_valid;
  logic [OFFSET_W-1:0] a_offset;
  logic                b_valid;
  res_t                b_res;
  res_t                map_res;
  logic                b_free;
  logic                a_adv;

  // handshake control
  assign b_free    = !b_valid || rsp.ready;
  assign a_adv     = a_valid && b_free;
  assign req.ready = !a_valid || b_free;
  assign cfg.ready = 1'b1;

  // mapping logic
  e2bmi_map u_map (
    .log_block_size (log_block_size),
    .byte_offset    (a_offset),
    .res            (map_res)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      log_block_size <= '0;
      a_valid        <= 1'b0;
      b_valid        <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        log_block_size <= cfg.log_block_size;
      end
      if (req.valid && req.ready) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
      if (a_adv) begin
        b_valid <= 1'b1;
      end else if (rsp.ready) begin
        b_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      a_offset <= req.byte_offset;
    end
    if (a_adv) begin
      b_res <= map_res;
    end
  end

  // result outputs
  assign rsp.valid           = b_valid;
  assign rsp.map_level       = b_res.map_level;
  assign rsp.pointer_slot    = b_res.pointer_slot;
  assign rsp.first_index     = b_res.first_index;
  assign rsp.second_index    = b_res.second_index;
  assign rsp.third_index     = b_res.third_index;
  assign rsp.offset_in_block = b_res.offset_in_block;
  assign rsp.beyond_range    = b_res.beyond_range;

`ifndef SYNTHESIS
  // a flagged offset carries no mapping
  a_beyond_zero: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_res.beyond_range) |->
      (b_res.map_level == LVL_DIRECT && b_res.pointer_slot == '0 &&
       b_res.first_index == '0 && b_res.second_index == '0 &&
       b_res.third_index == '0 && b_res.offset_in_block == '0))
    else $error("beyond-range result has nonzero fields");

  // slot agrees with level
  a_slot_level: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !b_res.beyond_range) |->
      ((b_res.map_level == LVL_DIRECT &&
        b_res.pointer_slot < SLOT_W'(DIRECT_SLOTS)) ||
       (b_res.map_level == LVL_SINGLE && b_res.pointer_slot == SLOT_SINGLE) ||
       (b_res.map_level == LVL_DOUBLE && b_res.pointer_slot == SLOT_DOUBLE) ||
       (b_res.map_level == LVL_TRIPLE && b_res.pointer_slot == SLOT_TRIPLE)))
    else $error("pointer slot does not match map level");

  // the third index stays zero below the triple level
  a_unused_idx: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_res.map_level != LVL_TRIPLE) |-> (b_res.third_index == '0))
    else $error("third index set below triple level");

  // an item that may advance reaches the result register
  a_advance: assert property (@(posedge clk) disable iff (rst)
    a_adv |=> b_valid)
    else $error("item lost between stages");

  // a full, stalled input stage takes no new item
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (a_valid && !b_free) |-> !req.ready)
    else $error("input accepted while input stage stalled");
`endif

endmodule

`default_nettype wire

>>> sim/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import e2bmi_pkg::*;

  // one row of the directed table: register setting, offset, optional typed mapping
  typedef struct {
    logic [LOG_W-1:0]    lg;
    logic [OFFSET_W-1:0] off;
    bit                  typed;
    res_t                want;
  } probe_t;

  // blocks covered by the whole map at 1, 2 and 4 KiB blocks
  localparam logic [63:0] REACH_1K = 64'd12 + 64'd256 + 64'd65536 + 64'd16777216;
  localparam logic [63:0] REACH_2K = 64'd12 + 64'd512 + 64'd262144 + 64'd134217728;
  localparam logic [63:0] REACH_4K = 64'd12 + 64'd1024 + 64'd1048576 + 64'd1073741824;

  localparam res_t ZERO_MAP = '0;
  localparam res_t LAST_BYTE_MAP = '{
    map_level: LVL_DIRECT, pointer_slot: '0, first_index: '0, second_index: '0,
    third_index: '0, offset_in_block: 12'd1023, beyond_range: 1'b0
  };
  localparam res_t BEYOND_MAP = '{
    map_level: LVL_DIRECT, pointer_slot: '0, first_index: '0, second_index: '0,
    third_index: '0, offset_in_block: '0, beyond_range: 1'b1
  };

  localparam int N_DIRECTED = 24;
  localparam int N_PHASES   = 5;
  localparam int PHASE_LEN  = 150;

  // directed stimulus: level edges at every block size, saturated setting, extremes
  probe_t directed_rows [N_DIRECTED] = '{
    '{2'd0, 48'd0,                                 1'b1, ZERO_MAP},
    '{2'd0, 48'd1023,                              1'b1, LAST_BYTE_MAP},
    '{2'd0, 48'd12287,                             1'b0, '0},
    '{2'd0, 48'd12288,                             1'b0, '0},
    '{2'd0, OFFSET_W'(64'd268 * 64'd1024 - 1),     1'b0, '0},
    '{2'd0, OFFSET_W'(64'd268 * 64'd1024),         1'b0, '0},
    '{2'd0, OFFSET_W'(64'd65804 * 64'd1024 - 1),   1'b0, '0},
    '{2'd0, OFFSET_W'(64'd65804 * 64'd1024),       1'b0, '0},
    '{2'd0, OFFSET_W'(REACH_1K * 64'd1024 - 1),    1'b0, '0},
    '{2'd0, OFFSET_W'(REACH_1K * 64'd1024),        1'b1, BEYOND_MAP},
    '{2'd0, 48'hFFFF_FFFF_FFFF,                    1'b1, BEYOND_MAP},
    '{2'd1, 48'd2047,                              1'b0, '0},
    '{2'd1, OFFSET_W'(64'd12 * 64'd2048),          1'b0, '0},
    '{2'd1, OFFSET_W'(REACH_2K * 64'd2048 - 1),    1'b0, '0},
    '{2'd1, OFFSET_W'(REACH_2K * 64'd2048),        1'b1, BEYOND_MAP},
    '{2'd2, 48'd4095,                              1'b0, '0},
    '{2'd2, OFFSET_W'(64'd1036 * 64'd4096),        1'b0, '0},
    '{2'd2, OFFSET_W'(REACH_4K * 64'd4096 - 1),    1'b0, '0},
    '{2'd2, OFFSET_W'(REACH_4K * 64'd4096),        1'b1, BEYOND_MAP},
    '{2'd2, 48'h5555_5555_5555,                    1'b0, '0},
    '{2'd2, 48'hAAAA_AAAA_AAAA,                    1'b0, '0},
    '{2'd3, OFFSET_W'(REACH_4K * 64'd4096 - 1),    1'b0, '0},
    '{2'd3, OFFSET_W'(REACH_4K * 64'd4096),        1'b1, BEYOND_MAP},
    '{2'd3, 48'hFFFF_FFFF_FFFF,                    1'b1, BEYOND_MAP}
  };

  logic clk;
  logic rst;

  e2bmi_off_if req ();
  e2bmi_res_if rsp ();
  e2bmi_cfg_if cfg ();

  ext2_block_map_indexer_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  res_t             mapped_q [$];
  logic [LOG_W-1:0] log_setting;
  int               mismatches;
  int               send_idle_pct;
  int               take_stall_pct;
  int               stall_left;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // expected mapping of one offset under a given log block size
  function automatic res_t map_offset(input logic [OFFSET_W-1:0] off,
                                      input logic [LOG_W-1:0] lg);
    res_t        r;
    int unsigned e;
    int unsigned bsh;
    int unsigned psh;
    logic [63:0] blk;
    logic [63:0] ptrs;
    logic [63:0] pmask;
    logic [63:0] inblk;
    r     = '0;
    e     = (lg > LOG_MAX) ? LOG_MAX : lg;
    bsh   = 10 + e;
    psh   = 8 + e;
    ptrs  = 64'd1 << psh;
    pmask = ptrs - 1;
    blk   = 64'(off) >> bsh;
    inblk = 64'(off) & ((64'd1 << bsh) - 1);
    r.offset_in_block = INBLK_W'(inblk);
    if (blk < DIRECT_SLOTS) begin
      r.map_level    = LVL_DIRECT;
      r.pointer_slot = SLOT_W'(blk);
    end else begin
      blk = blk - DIRECT_SLOTS;
      if (blk < ptrs) begin
        r.map_level    = LVL_SINGLE;
        r.pointer_slot = SLOT_SINGLE;
        r.first_index  = IDX_W'(blk);
      end else begin
        blk = blk - ptrs;
        if (blk < (ptrs << psh)) begin
          r.map_level    = LVL_DOUBLE;
          r.pointer_slot = SLOT_DOUBLE;
          r.first_index  = IDX_W'(blk >> psh);
          r.second_index = IDX_W'(blk & pmask);
        end else begin
          blk = blk - (ptrs << psh);
          if (blk < (ptrs << (2 * psh))) begin
            r.map_level    = LVL_TRIPLE;
            r.pointer_slot = SLOT_TRIPLE;
            r.first_index  = IDX_W'(blk >> (2 * psh));
            r.second_index = IDX_W'((blk >> psh) & pmask);
            r.third_index  = IDX_W'(blk & pmask);
          end else begin
            // past the triple tree: flag only
            r.offset_in_block = '0;
            r.beyond_range    = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  // idle length: mostly short, now and then long
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 80)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random offset aimed at one level of the map, its edges, or anywhere
  function automatic logic [OFFSET_W-1:0] random_offset(input logic [LOG_W-1:0] lg);
    logic [63:0] bnd [6];
    logic [63:0] p;
    logic [63:0] blk;
    logic [63:0] rnd;
    logic [63:0] off;
    int          sh;
    int          kind;
    int          region;
    sh     = (lg > LOG_MAX) ? 12 : 10 + lg;
    p      = 64'd1 << (sh - 2);
    bnd[0] = 0;
    bnd[1] = DIRECT_SLOTS;
    bnd[2] = bnd[1] + p;
    bnd[3] = bnd[2] + p * p;
    bnd[4] = bnd[3] + p * p * p;
    bnd[5] = 64'd1 << (OFFSET_W - sh);
    rnd    = {$urandom, $urandom};
    kind   = $urandom_range(0, 9);
    if (kind == 9)
      return rnd[OFFSET_W-1:0];
    if (kind == 8) begin
      blk = bnd[$urandom_range(1, 4)] - $urandom_range(0, 1);
    end else begin
      region = (kind == 0) ? 0 : (kind == 1) ? 1 : (kind <= 3) ? 2 : (kind <= 6) ? 3 : 4;
      blk = bnd[region] + rnd % (bnd[region+1] - bnd[region]);
    end
    rnd = {$urandom, $urandom};
    off = (blk << sh) | (rnd & ((64'd1 << sh) - 1));
    return off[OFFSET_W-1:0];
  endfunction

  // one offset transfer; valid stays high across back-to-back offsets
  task automatic send_offset(input logic [OFFSET_W-1:0] off, input bit typed,
                             input res_t want);
    int gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.byte_offset <= off;
    do @(posedge clk); while (!req.ready);
    mapped_q.push_back(typed ? want : map_offset(off, log_setting));
  endtask

  // register write once every mapping in flight has come back
  task automatic write_log(input logic [LOG_W-1:0] lg);
    req.valid <= 1'b0;
    while (mapped_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg.valid          <= 1'b1;
    cfg.log_block_size <= lg;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid   <= 1'b0;
    log_setting = lg;
  endtask

  task automatic check_field(input string name, input logic [11:0] want,
                             input logic [11:0] got);
    if (got !== want) begin
      $display("%0t %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // compare one result transfer with the oldest expected mapping
  task automatic check_result();
    res_t want;
    if (mapped_q.size() == 0) begin
      $display("%0t unexpected result expected none actual slot %0h", $time,
               rsp.pointer_slot);
      mismatches++;
      return;
    end
    want = mapped_q.pop_front();
    check_field("map_level",       12'(want.map_level),       12'(rsp.map_level));
    check_field("pointer_slot",    12'(want.pointer_slot),    12'(rsp.pointer_slot));
    check_field("first_index",     12'(want.first_index),     12'(rsp.first_index));
    check_field("second_index",    12'(want.second_index),    12'(rsp.second_index));
    check_field("third_index",     12'(want.third_index),     12'(rsp.third_index));
    check_field("offset_in_block", want.offset_in_block,      rsp.offset_in_block);
    check_field("beyond_range",    12'(want.beyond_range),    12'(rsp.beyond_range));
  endtask

  // result side: check transfers, stall ready at random
  always @(posedge clk) begin
    if (rsp.valid && rsp.ready)
      check_result();
    if (stall_left > 0) begin
      rsp.ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < take_stall_pct) begin
      rsp.ready  <= 1'b0;
      stall_left <= pick_gap() - 1;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // stimulus
  initial begin
    int lg_seq [N_PHASES] = '{2, 0, 3, 1, 0};
    int idle_seq [N_PHASES] = '{30, 0, 50, 10, 20};
    logic [LOG_W-1:0] lg;
    rst                = 1'b1;
    req.valid          = 1'b0;
    req.byte_offset    = '0;
    cfg.valid          = 1'b0;
    cfg.log_block_size = '0;
    rsp.ready          = 1'b0;
    stall_left         = 0;
    mismatches         = 0;
    log_setting        = '0;
    send_idle_pct      = 20;
    take_stall_pct     = 20;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].lg != log_setting)
        write_log(directed_rows[i].lg);
      send_offset(directed_rows[i].off, directed_rows[i].typed, directed_rows[i].want);
    end

    // random phases, one block size and idle mix each
    for (int ph = 0; ph < N_PHASES; ph++) begin
      lg = (ph == N_PHASES - 1) ? LOG_W'($urandom_range(0, 3)) : LOG_W'(lg_seq[ph]);
      write_log(lg);
      send_idle_pct  = idle_seq[ph];
      take_stall_pct = idle_seq[(ph + 2) % N_PHASES];
      for (int n = 0; n < PHASE_LEN; n++)
        send_offset(random_offset(log_setting), 1'b0, '0);
    end

    // drain
    req.valid <= 1'b0;
    while (mapped_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
rtl/e2bmi_pkg.sv
rtl/e2bmi_off_if.sv
rtl/e2bmi_res_if.sv
rtl/e2bmi_cfg_if.sv
rtl/e2bmi_map.sv
rtl/ext2_block_map_indexer_top.sv
sim/tb.sv
